// ===== sv/sparc_v8_instruction_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// SPARC V8 instruction decoder assertion macros
// Shared property macros for the checker of the decoder.
// ----------------------------------------------------------------------------
`ifndef SPARC_V8_INSTRUCTION_DECODER_DEFINES_SVH
`define SPARC_V8_INSTRUCTION_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPDEC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SPDEC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/spdec_pkg.sv =====
// ----------------------------------------------------------------------------
// SPARC V8 instruction decoder package
// Operation classes, opcode tables, error codes and stage payload types.
// ----------------------------------------------------------------------------
package spdec_pkg;

  localparam int CLS_W = 7;

  localparam logic [CLS_W-1:0] CLS_UNKNOWN  = 7'd0;
  localparam logic [CLS_W-1:0] CLS_CALL     = 7'd1;
  localparam logic [CLS_W-1:0] CLS_BRANCH   = 7'd2;
  localparam logic [CLS_W-1:0] CLS_SETHI    = 7'd3;
  localparam logic [CLS_W-1:0] CLS_NOP      = 7'd4;
  localparam logic [CLS_W-1:0] CLS_CYCPRINT = 7'd5;
  localparam logic [CLS_W-1:0] CLS_CYCCLEAR = 7'd6;
  localparam logic [CLS_W-1:0] CLS_RDY      = 7'd46;

  localparam logic [1:0] OP_FMT2 = 2'd0;
  localparam logic [1:0] OP_CALL = 2'd1;
  localparam logic [1:0] OP_ALU  = 2'd2;
  localparam logic [1:0] OP_MEM  = 2'd3;

  localparam logic [2:0] FMT2_BRANCH = 3'd2;
  localparam logic [2:0] FMT2_SETHI  = 3'd4;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_UNKNOWN = 2'd1;
  localparam logic [1:0] ERR_Y_SRC   = 2'd2;

  localparam logic [1:0] REG_CYCLE_EXT_OP2  = 2'd0;
  localparam logic [1:0] REG_CYCLE_PRINT_RD = 2'd1;
  localparam logic [1:0] REG_CYCLE_CLEAR_RD = 2'd2;
  localparam logic [1:0] REG_Y_SOURCE_REG   = 2'd3;

  // op3 to class for arithmetic/logic instructions; zero marks an unknown code.
  localparam logic [CLS_W-1:0] ALU_CLASS [64] = '{
    7'd22, 7'd7,  7'd11, 7'd15, 7'd28, 7'd9,  7'd13, 7'd17,
    7'd24, 7'd0,  7'd35, 7'd36, 7'd30, 7'd0,  7'd39, 7'd40,
    7'd23, 7'd8,  7'd12, 7'd16, 7'd29, 7'd10, 7'd14, 7'd18,
    7'd25, 7'd0,  7'd37, 7'd38, 7'd31, 7'd0,  7'd41, 7'd42,
    7'd26, 7'd32, 7'd27, 7'd33, 7'd34, 7'd19, 7'd20, 7'd21,
    7'd46, 7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,
    7'd47, 7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,
    7'd45, 7'd0,  7'd0,  7'd0,  7'd43, 7'd44, 7'd0,  7'd0
  };

  // op3 to class for load/store instructions; zero marks an unknown code.
  localparam logic [CLS_W-1:0] MEM_CLASS [64] = '{
    7'd52, 7'd50, 7'd51, 7'd53, 7'd62, 7'd60, 7'd61, 7'd63,
    7'd0,  7'd48, 7'd49, 7'd0,  7'd0,  7'd68, 7'd0,  7'd70,
    7'd58, 7'd56, 7'd57, 7'd59, 7'd66, 7'd64, 7'd65, 7'd67,
    7'd0,  7'd54, 7'd55, 7'd0,  7'd0,  7'd69, 7'd0,  7'd71,
    7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,
    7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,
    7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,
    7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0
  };

  typedef struct packed {
    logic [2:0] cycle_ext_op2;
    logic [4:0] cycle_print_rd;
    logic [4:0] cycle_clear_rd;
    logic [4:0] y_source_reg;
  } cfg_t;

  // Raw request after classification.
  typedef struct packed {
    logic [31:0]      word;
    logic [31:0]      index;
    logic [CLS_W-1:0] cls;
  } cls_stage_t;

  // All result fields except the branch target.
  typedef struct packed {
    logic [CLS_W-1:0]   operation_class;
    logic [1:0]         operand_count;
    logic [4:0]         dest_reg;
    logic [4:0]         first_src;
    logic [4:0]         second_src;
    logic               third_is_immediate;
    logic signed [31:0] immediate_value;
    logic [3:0]         branch_condition;
    logic [1:0]         error_code;
  } res_t;

  typedef struct packed {
    res_t        res;
    logic [31:0] index;
    logic [31:0] disp;
    logic        tgt_en;
  } fld_stage_t;

  typedef struct packed {
    res_t        res;
    logic [31:0] target_index;
  } out_t;

endpackage

// ===== sv/spdec_classify.sv =====
// ----------------------------------------------------------------------------
// SPARC V8 decoder, stage 1
// Maps op/op2/op3 and the extension registers to the dense operation class.
// ----------------------------------------------------------------------------
module spdec_classify (
  input  logic                      clk,
  input  logic                      rst_n,
  input  spdec_pkg::cfg_t           cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [31:0]               in_word,
  input  logic [31:0]               in_index,
  output logic                      out_valid,
  input  logic                      out_ready,
  output spdec_pkg::cls_stage_t     out_data
);
  import spdec_pkg::*;

  logic       valid_r;
  cls_stage_t data_r;
  cls_stage_t data_nxt;
  logic [1:0] op;
  logic [2:0] op2;
  logic [5:0] op3;
  logic [4:0] rd;

  assign op  = in_word[31:30];
  assign op2 = in_word[24:22];
  assign op3 = in_word[24:19];
  assign rd  = in_word[29:25];

  always_comb begin
    data_nxt.word  = in_word;
    data_nxt.index = in_index;
    data_nxt.cls   = CLS_UNKNOWN;
    unique case (op)
      OP_CALL: data_nxt.cls = CLS_CALL;
      OP_ALU:  data_nxt.cls = ALU_CLASS[op3];
      OP_MEM:  data_nxt.cls = MEM_CLASS[op3];
      OP_FMT2: begin
        // Bicc and SETHI win over the extension op2 code.
        if (op2 == FMT2_BRANCH) begin
          data_nxt.cls = CLS_BRANCH;
        end else if (op2 == FMT2_SETHI) begin
          data_nxt.cls = CLS_SETHI;
        end else if (op2 == cfg.cycle_ext_op2) begin
          if (rd == cfg.cycle_print_rd) begin
            data_nxt.cls = CLS_CYCPRINT;
          end else if (rd == cfg.cycle_clear_rd) begin
            data_nxt.cls = CLS_CYCCLEAR;
          end
        end
      end
      default: data_nxt.cls = CLS_UNKNOWN;
    endcase
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== sv/spdec_fields.sv =====
// ----------------------------------------------------------------------------
// SPARC V8 decoder, stage 2
// Extracts the operand fields for the class and prepares the displacement.
// ----------------------------------------------------------------------------
module spdec_fields (
  input  logic                      clk,
  input  logic                      rst_n,
  input  spdec_pkg::cfg_t           cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  spdec_pkg::cls_stage_t     in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output spdec_pkg::fld_stage_t     out_data
);
  import spdec_pkg::*;

  logic        valid_r;
  fld_stage_t  data_r;
  fld_stage_t  data_nxt;
  logic [31:0] w;
  logic [4:0]  rd;
  logic [4:0]  rs1;
  logic [21:0] imm22;

  assign w     = in_data.word;
  assign rd    = w[29:25];
  assign rs1   = w[18:14];
  assign imm22 = w[21:0];

  always_comb begin
    data_nxt       = '0;
    data_nxt.index = in_data.index;
    data_nxt.res.operation_class = in_data.cls;
    unique case (in_data.cls) inside
      CLS_UNKNOWN: begin
        data_nxt.res.error_code = ERR_UNKNOWN;
      end
      CLS_CALL: begin
        data_nxt.disp   = {{2{w[29]}}, w[29:0]};
        data_nxt.tgt_en = 1'b1;
        data_nxt.res.operand_count = 2'd1;
      end
      CLS_BRANCH: begin
        data_nxt.disp   = {{10{w[21]}}, w[21:0]};
        data_nxt.tgt_en = 1'b1;
        data_nxt.res.branch_condition = w[28:25];
        data_nxt.res.operand_count    = 2'd2;
      end
      CLS_SETHI: begin
        // SETHI of zero into the zero register is the canonical NOP.
        if (rd == 5'd0 && imm22 == 22'd0) begin
          data_nxt.res.operation_class = CLS_NOP;
        end else begin
          data_nxt.res.operand_count   = 2'd2;
          data_nxt.res.dest_reg        = rd;
          data_nxt.res.immediate_value = {10'd0, imm22};
        end
      end
      CLS_CYCPRINT, CLS_CYCCLEAR: begin
        data_nxt.res.operand_count = 2'd0;
      end
      CLS_RDY: begin
        data_nxt.res.operand_count = 2'd2;
        data_nxt.res.dest_reg      = rd;
        data_nxt.res.first_src     = rs1;
        if (rs1 != cfg.y_source_reg) begin
          data_nxt.res.error_code = ERR_Y_SRC;
        end
      end
      default: begin
        data_nxt.res.operand_count = 2'd3;
        data_nxt.res.dest_reg      = rd;
        data_nxt.res.first_src     = rs1;
        if (w[13]) begin
          data_nxt.res.third_is_immediate = 1'b1;
          data_nxt.res.immediate_value    = {{19{w[12]}}, w[12:0]};
        end else begin
          data_nxt.res.second_src = w[4:0];
        end
      end
    endcase
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== sv/spdec_target.sv =====
// ----------------------------------------------------------------------------
// SPARC V8 decoder, stage 3
// Adds the displacement to the instruction index for calls and branches; holds the result.
// ----------------------------------------------------------------------------
module spdec_target (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  spdec_pkg::fld_stage_t     in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output spdec_pkg::out_t           out_data
);
  import spdec_pkg::*;

  logic        valid_r;
  out_t        data_r;
  out_t        data_nxt;
  logic [31:0] sum;

  // The add wraps at 32 bits, as the target index does.
  assign sum = in_data.index + in_data.disp;

  always_comb begin
    data_nxt.res          = in_data.res;
    data_nxt.target_index = in_data.tgt_en ? sum : 32'd0;
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== sv/sparc_v8_instruction_decoder.sv =====
// ----------------------------------------------------------------------------
// SPARC V8 instruction decoder
// Three-stage decoder for SPARC V8 integer instruction words.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// in_       slave      instruction word and its index
// out_      master     decoded class, operands, immediate, target, error
// cfg_      write      extension op2, cycle rd codes, Y source register
//
// One request enters per cycle unless a stall on out_tready has filled the stages.
// The three stages are classify, field extraction and the 32-bit target add.
// Reset is synchronous; it clears the stage valid bits and presets the cfg registers.
// Each stage holds its request while the next one is full and stalled, so a
// stall on out_tready backs up one stage at a time without loss.
// ----------------------------------------------------------------------------
module sparc_v8_instruction_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // instruction_word[31:0], instruction_index[63:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  // operation_class[6:0], operand_count[8:7], dest_reg[13:9], first_src[18:14],
  // second_src[23:19], third_is_immediate[24], immediate_value[56:25],
  // branch_condition[60:57], target_index[92:61], error_code[94:93], zero[95]
  output logic [95:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_wdata
);
  import spdec_pkg::*;

  cfg_t       cfg_r;
  cls_stage_t cls_data;
  fld_stage_t fld_data;
  out_t       res_data;
  logic       cls_valid;
  logic       cls_ready;
  logic       fld_valid;
  logic       fld_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cycle_ext_op2  <= 3'd0;
      cfg_r.cycle_print_rd <= 5'd0;
      cfg_r.cycle_clear_rd <= 5'd1;
      cfg_r.y_source_reg   <= 5'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CYCLE_EXT_OP2:  cfg_r.cycle_ext_op2  <= cfg_wdata[2:0];
        REG_CYCLE_PRINT_RD: cfg_r.cycle_print_rd <= cfg_wdata;
        REG_CYCLE_CLEAR_RD: cfg_r.cycle_clear_rd <= cfg_wdata;
        REG_Y_SOURCE_REG:   cfg_r.y_source_reg   <= cfg_wdata;
        default:            cfg_r.y_source_reg   <= cfg_r.y_source_reg;
      endcase
    end
  end

  spdec_classify u_classify (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_word   (in_tdata[31:0]),
    .in_index  (in_tdata[63:32]),
    .out_valid (cls_valid),
    .out_ready (cls_ready),
    .out_data  (cls_data)
  );

  spdec_fields u_fields (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (cls_valid),
    .in_ready  (cls_ready),
    .in_data   (cls_data),
    .out_valid (fld_valid),
    .out_ready (fld_ready),
    .out_data  (fld_data)
  );

  spdec_target u_target (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fld_valid),
    .in_ready  (fld_ready),
    .in_data   (fld_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (res_data)
  );

  assign out_tdata = {
    1'b0,
    res_data.res.error_code,
    res_data.target_index,
    res_data.res.branch_condition,
    res_data.res.immediate_value,
    res_data.res.third_is_immediate,
    res_data.res.second_src,
    res_data.res.first_src,
    res_data.res.dest_reg,
    res_data.res.operand_count,
    res_data.res.operation_class
  };

endmodule

// ===== sv/spdec_chk.sv =====
// ----------------------------------------------------------------------------
// SPARC V8 decoder port checker
// Watches the result channel of the decoder for consistent decoded fields.
// ----------------------------------------------------------------------------
`include "sparc_v8_instruction_decoder_defines.svh"

module spdec_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [95:0] out_tdata
);
  import spdec_pkg::*;

  logic [CLS_W-1:0] cls;
  logic [1:0]       cnt;
  logic             ibit;
  logic [1:0]       err;

  assign cls  = out_tdata[6:0];
  assign cnt  = out_tdata[8:7];
  assign ibit = out_tdata[24];
  assign err  = out_tdata[94:93];

  `SPDEC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata), "result changed while stalled")
  `SPDEC_ASSERT_IMPLY(a_unknown_err, clk, rst_n, out_tvalid && cls == CLS_UNKNOWN,
    err == ERR_UNKNOWN && cnt == 2'd0, "unknown class without unknown error")
  `SPDEC_ASSERT_IMPLY(a_err_unknown, clk, rst_n, out_tvalid && err == ERR_UNKNOWN,
    cls == CLS_UNKNOWN, "unknown error on a known class")
  `SPDEC_ASSERT_IMPLY(a_imm_three_ops, clk, rst_n, out_tvalid && ibit,
    cnt == 2'd3, "immediate flag outside a three-operand form")

endmodule

bind sparc_v8_instruction_decoder spdec_chk u_spdec_chk (.*);

// ===== tb/decode_checker.sv =====
// ----------------------------------------------------------------------------
// SPARC V8 decoder result checker
// Watches the request, result and register write ports of the decoder. It
// decodes every accepted request on its own and compares each result field
// by field with the oldest decode still waiting.
// ----------------------------------------------------------------------------
module decode_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,   // instruction_word[31:0], instruction_index[63:32]
  input  logic        out_tvalid,
  input  logic        out_tready,
  // operation_class[6:0], operand_count[8:7], dest_reg[13:9], first_src[18:14],
  // second_src[23:19], third_is_immediate[24], immediate_value[56:25],
  // branch_condition[60:57], target_index[92:61], error_code[94:93], zero[95]
  input  logic [95:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_wdata,
  output int          pending,
  output int          failures
);
  import spdec_pkg::*;

  typedef struct packed {
    logic [6:0]  op_class;
    logic [1:0]  operands;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic        imm_sel;
    logic [31:0] imm;
    logic [3:0]  cond;
    logic [31:0] target;
    logic [1:0]  err;
  } decode_t;

  // op3 to class for the arithmetic group; zero is an undefined op3.
  localparam logic [6:0] ALU_OP3_CLASS [64] = '{
    7'd22, 7'd7,  7'd11, 7'd15, 7'd28, 7'd9,  7'd13, 7'd17,
    7'd24, 7'd0,  7'd35, 7'd36, 7'd30, 7'd0,  7'd39, 7'd40,
    7'd23, 7'd8,  7'd12, 7'd16, 7'd29, 7'd10, 7'd14, 7'd18,
    7'd25, 7'd0,  7'd37, 7'd38, 7'd31, 7'd0,  7'd41, 7'd42,
    7'd26, 7'd32, 7'd27, 7'd33, 7'd34, 7'd19, 7'd20, 7'd21,
    7'd46, 7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,
    7'd47, 7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,
    7'd45, 7'd0,  7'd0,  7'd0,  7'd43, 7'd44, 7'd0,  7'd0
  };

  // op3 to class for loads and stores; the upper half is all undefined.
  localparam logic [6:0] LDST_OP3_CLASS [32] = '{
    7'd52, 7'd50, 7'd51, 7'd53, 7'd62, 7'd60, 7'd61, 7'd63,
    7'd0,  7'd48, 7'd49, 7'd0,  7'd0,  7'd68, 7'd0,  7'd70,
    7'd58, 7'd56, 7'd57, 7'd59, 7'd66, 7'd64, 7'd65, 7'd67,
    7'd0,  7'd54, 7'd55, 7'd0,  7'd0,  7'd69, 7'd0,  7'd71
  };

  logic [2:0] ext_op2;
  logic [4:0] print_rd;
  logic [4:0] clear_rd;
  logic [4:0] y_src;

  decode_t decode_q [$];
  int      results_seen = 0;

  initial begin
    pending  = 0;
    failures = 0;
  end

  function automatic decode_t decode_predict(logic [31:0] word, logic [31:0] index);
    decode_t    d;
    logic [1:0] op;
    logic [2:0] op2;
    logic [5:0] op3;
    logic [4:0] rd;
    d   = '0;
    op  = word[31:30];
    op2 = word[24:22];
    op3 = word[24:19];
    rd  = word[29:25];

    case (op)
      OP_CALL: d.op_class = CLS_CALL;
      OP_ALU:  d.op_class = ALU_OP3_CLASS[op3];
      OP_MEM:  d.op_class = op3[5] ? CLS_UNKNOWN : LDST_OP3_CLASS[op3[4:0]];
      default: begin
        // Bicc and SETHI win over the cycle extension when op2 codes collide.
        if (op2 == FMT2_BRANCH)
          d.op_class = CLS_BRANCH;
        else if (op2 == FMT2_SETHI)
          d.op_class = CLS_SETHI;
        else if (op2 == ext_op2 && rd == print_rd)
          d.op_class = CLS_CYCPRINT;
        else if (op2 == ext_op2 && rd == clear_rd)
          d.op_class = CLS_CYCCLEAR;
        else
          d.op_class = CLS_UNKNOWN;
      end
    endcase

    case (d.op_class)
      CLS_UNKNOWN: d.err = ERR_UNKNOWN;
      CLS_CALL: begin
        d.operands = 2'd1;
        d.target   = index + {{2{word[29]}}, word[29:0]};
      end
      CLS_BRANCH: begin
        d.operands = 2'd2;
        d.cond     = word[28:25];
        d.target   = index + {{10{word[21]}}, word[21:0]};
      end
      CLS_SETHI: begin
        if (rd == 5'd0 && word[21:0] == 22'd0) begin
          d.op_class = CLS_NOP;
        end else begin
          d.operands = 2'd2;
          d.rd       = rd;
          d.imm      = {10'd0, word[21:0]};
        end
      end
      CLS_CYCPRINT, CLS_CYCCLEAR: ;
      CLS_RDY: begin
        d.operands = 2'd2;
        d.rd       = rd;
        d.rs1      = word[18:14];
        if (word[18:14] != y_src)
          d.err = ERR_Y_SRC;
      end
      default: begin
        d.operands = 2'd3;
        d.rd       = rd;
        d.rs1      = word[18:14];
        if (word[13]) begin
          d.imm_sel = 1'b1;
          d.imm     = {{19{word[12]}}, word[12:0]};
        end else begin
          d.rs2 = word[4:0];
        end
      end
    endcase
    return d;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    failures++;
    // Keep the log readable if the block is badly broken.
    if (failures <= 100)
      $display("result %0d: %s got %h expected %h", results_seen, what, got, want);
  endtask

  task automatic compare_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report(what, got, want);
  endtask

  always @(posedge clk) begin
    decode_t want;
    if (!rst_n) begin
      ext_op2  <= 3'd0;
      print_rd <= 5'd0;
      clear_rd <= 5'd1;
      y_src    <= 5'd0;
      decode_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CYCLE_EXT_OP2:  ext_op2  <= cfg_wdata[2:0];
          REG_CYCLE_PRINT_RD: print_rd <= cfg_wdata;
          REG_CYCLE_CLEAR_RD: clear_rd <= cfg_wdata;
          REG_Y_SOURCE_REG:   y_src    <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        decode_q.push_back(decode_predict(in_tdata[31:0], in_tdata[63:32]));
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (decode_q.size() == 0) begin
          report("result with no request waiting, class", 32'(out_tdata[6:0]), 32'd0);
        end else begin
          want = decode_q.pop_front();
          compare_field("operation_class", 32'(out_tdata[6:0]), 32'(want.op_class));
          compare_field("operand_count", 32'(out_tdata[8:7]), 32'(want.operands));
          compare_field("dest_reg", 32'(out_tdata[13:9]), 32'(want.rd));
          compare_field("first_src", 32'(out_tdata[18:14]), 32'(want.rs1));
          compare_field("second_src", 32'(out_tdata[23:19]), 32'(want.rs2));
          compare_field("third_is_immediate", 32'(out_tdata[24]), 32'(want.imm_sel));
          compare_field("immediate_value", out_tdata[56:25], want.imm);
          compare_field("branch_condition", 32'(out_tdata[60:57]), 32'(want.cond));
          compare_field("target_index", out_tdata[92:61], want.target);
          compare_field("error_code", 32'(out_tdata[94:93]), 32'(want.err));
        end
      end
    end
    pending <= decode_q.size();
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// SPARC V8 decoder testbench
// Drives directed and random instruction words through the decoder under
// several register settings, with random gaps on both channels and one long
// output stall, and leaves the checking to the checker module.
// ----------------------------------------------------------------------------
module tb;
  import spdec_pkg::*;

  localparam int         STALL_LIMIT   = 2000;
  localparam int         RANDOM_ITEMS  = 280;
  localparam int         HOLD_CYCLES   = 250;
  localparam int         HOLD_AFTER    = 400;
  localparam logic [5:0] OP3_RDY       = 6'h28;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;      // instruction_word[31:0], instruction_index[63:32]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // operation_class[6:0], operand_count[8:7], dest_reg[13:9], first_src[18:14],
  // second_src[23:19], third_is_immediate[24], immediate_value[56:25],
  // branch_condition[60:57], target_index[92:61], error_code[94:93], zero[95]
  logic [95:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [4:0]  cfg_wdata = '0;

  int pending;
  int failures;
  int idle_cycles = 0;
  int results_taken = 0;
  bit send_calm = 0;

  // Register values as last written, used to aim the random words.
  logic [2:0] ext_op2 = 3'd0;
  logic [4:0] print_rd = 5'd0;
  logic [4:0] clear_rd = 5'd1;
  logic [4:0] y_src = 5'd0;

  always #2 clk = ~clk;

  sparc_v8_instruction_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  decode_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .pending   (pending),
    .failures  (failures)
  );

  // Mostly short gaps, now and then a long one, none at all in calm stretches.
  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55)
      return 0;
    else if (r < 88)
      return $urandom_range(1, 3);
    else if (r < 97)
      return $urandom_range(4, 10);
    else
      return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] random_index();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom_range(0, 255);
      default: return $urandom();
    endcase
  endfunction

  // Mostly well-formed words of every format with random content, some noise.
  function automatic logic [31:0] random_word();
    logic [31:0] w;
    int          pick;
    w    = $urandom();
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 7) == 0)
      w[12:0] = $urandom_range(0, 1) ? 13'h1000 : 13'h0FFF;
    if (pick < 8) begin
      return w;
    end else if (pick < 16) begin
      w[31:30] = OP_CALL;
    end else if (pick < 28) begin
      w[31:30] = OP_FMT2;
      w[24:22] = FMT2_BRANCH;
    end else if (pick < 38) begin
      w[31:30] = OP_FMT2;
      w[24:22] = FMT2_SETHI;
      if ($urandom_range(0, 4) == 0) begin
        w[29:25] = 5'd0;
        w[21:0]  = 22'd0;
      end
    end else if (pick < 48) begin
      w[31:30] = OP_FMT2;
      w[24:22] = ext_op2;
      case ($urandom_range(0, 2))
        0:       w[29:25] = print_rd;
        1:       w[29:25] = clear_rd;
        default: ;
      endcase
    end else if (pick < 52) begin
      w[31:30] = OP_FMT2;
    end else if (pick < 80) begin
      w[31:30] = OP_ALU;
      if ($urandom_range(0, 7) == 0) begin
        w[24:19] = OP3_RDY;
        if ($urandom_range(0, 1))
          w[18:14] = y_src;
      end
    end else begin
      w[31:30] = OP_MEM;
      if ($urandom_range(0, 3) != 0)
        w[24] = 1'b0;
    end
    return w;
  endfunction

  task automatic send_request(logic [31:0] word, logic [31:0] index);
    int gap;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {index, word};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_registers(logic [2:0] op2, logic [4:0] prd, logic [4:0] crd,
                                 logic [4:0] ysrc);
    // Let the last request clear the pipeline before the settings change; the
    // extra edge lets the count pick up a request accepted at this edge.
    @(posedge clk);
    wait (pending == 0);
    repeat (4) @(posedge clk);
    ext_op2  = op2;
    print_rd = prd;
    clear_rd = crd;
    y_src    = ysrc;
    cfg_we    <= 1'b1;
    cfg_index <= REG_CYCLE_EXT_OP2;
    cfg_wdata <= {2'b00, op2};
    @(posedge clk);
    cfg_index <= REG_CYCLE_PRINT_RD;
    cfg_wdata <= prd;
    @(posedge clk);
    cfg_index <= REG_CYCLE_CLEAR_RD;
    cfg_wdata <= crd;
    @(posedge clk);
    cfg_index <= REG_Y_SOURCE_REG;
    cfg_wdata <= ysrc;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_requests(int count);
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0)
        send_calm = ($urandom_range(0, 3) == 0);
      send_request(random_word(), random_index());
    end
    in_tvalid <= 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Settings after reset: cycle op2 0, print rd 0, clear rd 1, Y source 0.
    send_request(32'h5FFF_FFFF, 32'h0000_0000);  // call, largest forward disp30
    send_request(32'h6000_0000, 32'h0000_0010);  // call, most negative disp30
    send_request(32'h4000_0001, 32'hFFFF_FFFF);  // call, target wraps to zero
    send_request(32'h3E9F_FFFF, 32'h0000_0000);  // Bicc, annul set, cond 15
    send_request(32'h00A0_0000, 32'h0000_0005);  // Bicc, most negative disp22
    send_request(32'h0100_0000, random_index());  // SETHI of zero to g0 is a NOP
    send_request(32'h0100_0001, random_index());  // SETHI to g0, nonzero value
    send_request(32'h3F3F_FFFF, random_index());  // SETHI, all ones
    send_request(32'h0300_0000, random_index());  // SETHI of zero to g1
    send_request(32'h0000_0000, random_index());  // cycle print
    send_request(32'h0200_0000, random_index());  // cycle clear
    send_request(32'h0400_0000, random_index());  // cycle op2, rd matches neither
    send_request(32'h0040_0000, random_index());  // undefined op2
    send_request(32'h8740_0000, random_index());  // RDY from Y
    send_request(32'h8743_C000, random_index());  // RDY from a non-Y source
    send_request(32'hBE07_F000, random_index());  // ADD, most negative simm13
    send_request(32'h80A0_3FFF, random_index());  // SUBCC, simm13 of -1
    send_request(32'h8038_1FFF, random_index());  // XNOR, register form
    send_request(32'h8048_0000, random_index());  // undefined arithmetic op3
    send_request(32'h8180_3FFF, random_index());  // WRY, immediate form
    send_request(32'h81C7_E008, random_index());  // JMPL return
    send_request(32'hC418_0000, random_index());  // LDD
    send_request(32'hC0F8_0005, random_index());  // SWAPA
    send_request(32'hC100_0000, random_index());  // undefined memory op3
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);   // all ones
    random_requests(RANDOM_ITEMS);

    write_registers(3'd7, 5'd31, 5'd0, 5'd31);
    random_requests(RANDOM_ITEMS);
    // Cycle op2 on the Bicc code, and both rd values equal.
    write_registers(FMT2_BRANCH, 5'd5, 5'd5, 5'd17);
    random_requests(RANDOM_ITEMS);
    // Cycle op2 on the SETHI code.
    write_registers(FMT2_SETHI, 5'd0, 5'd31, 5'd0);
    random_requests(RANDOM_ITEMS);
    write_registers(3'd0, 5'd31, 5'd31, 5'd1);
    random_requests(RANDOM_ITEMS);
    repeat (2) begin
      write_registers(3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)),
                      5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
      random_requests(RANDOM_ITEMS);
    end

    @(posedge clk);
    wait (pending == 0);
    repeat (10) @(posedge clk);
    if (failures == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Result side: random ready pattern, plus one long hold once traffic is going.
  initial begin
    int  run;
    int  gap;
    bit  calm;
    bit  held;
    held = 0;
    calm = 0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0)
        calm = !calm;
      run = calm ? $urandom_range(50, 150) : $urandom_range(1, 8);
      out_tready <= 1'b1;
      repeat (run) @(posedge clk);
      if (!held && results_taken >= HOLD_AFTER) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1;
      end else begin
        gap = pick_gap(calm);
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (out_tvalid && out_tready)
      results_taken <= results_taken + 1;
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule
